@@ hw/rtl/esp_pkg.sv @@
// package: types, constants and g.711 expanders for the echo spike profiler
`timescale 1ns / 1ps
package esp_pkg;

  localparam int MaxSamplesDefault = 1024;
  localparam int IdxW = 10;

  localparam logic [1:0] RegMuLaw     = 2'd0;
  localparam logic [1:0] RegAfterCanc = 2'd1;
  localparam logic [1:0] RegTaps      = 2'd2;
  localparam logic [1:0] RegThreshold = 2'd3;

  localparam logic [2:0] VerdictSilent  = 3'd0;
  localparam logic [2:0] VerdictNoEcho  = 3'd1;
  localparam logic [2:0] VerdictRemoved = 3'd2;
  localparam logic [2:0] VerdictBeyond  = 3'd3;
  localparam logic [2:0] VerdictEndsOut = 3'd4;
  localparam logic [2:0] VerdictWithin  = 3'd5;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic [IdxW-1:0]    peak_index;
    logic signed [15:0] peak_value;
    logic [IdxW-1:0]    first_index;
    logic signed [15:0] first_value;
    logic [IdxW-1:0]    last_index;
    logic signed [15:0] last_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_req_t;

  // decoded sample as queued from front to back
  typedef struct packed {
    logic [15:0] lin;
    logic [11:0] mag;
    logic        last;
  } dec_item_t;

  function automatic logic [15:0] expand_mu(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    begin
      u = ~code;
      t = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
      t = t - 16'h0084;
      expand_mu = u[7] ? (16'd0 - t) : t;
    end
  endfunction

  function automatic logic [15:0] expand_a(input logic [7:0] code);
    logic [7:0]  a;
    logic [15:0] i;
    begin
      a = code ^ 8'h55;
      i = {8'd0, a[3:0], 4'd0};
      if (a[6:4] != 3'd0) i = (i + 16'h0100) << (a[6:4] - 3'd1);
      expand_a = a[7] ? i : (16'd0 - i);
    end
  endfunction

endpackage

@@ hw/rtl/esp_front.sv @@
// front: g.711 decode and magnitude, registered into a two-entry queue
`timescale 1ns / 1ps
module esp_front import esp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mu_law,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      q_valid,
  input  logic      q_ready,
  output dec_item_t q_data
);
  dec_item_t   slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic [15:0] lin;
  logic [15:0] folded;
  dec_item_t   dec;
  logic        push, pop;

  always_comb begin
    lin = mu_law ? expand_mu(in_data.code_byte) : expand_a(in_data.code_byte);
    folded = lin[15] ? ~lin : lin;
    dec.lin = lin;
    dec.mag = folded[14:3];
    dec.last = in_data.last_sample;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= dec;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");
endmodule

@@ hw/rtl/esp_back.sv @@
// back: peak and echo tracking, verdict and output register
`timescale 1ns / 1ps
module esp_back import esp_pkg::*; #(
  parameter int MAX_SAMPLES = MaxSamplesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        after_canceller,
  input  logic [15:0] canceller_taps,
  input  logic [11:0] echo_threshold,
  input  logic        q_valid,
  output logic        q_ready,
  input  dec_item_t   q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
  localparam int CntW = $clog2(MAX_SAMPLES);

  logic [CntW-1:0] sample_counter;
  logic [11:0]     peak_magnitude;
  logic [CntW-1:0] peak_position, first_position, last_position;
  logic [15:0]     peak_linear, first_linear, last_linear;
  logic            echo_seen;

  logic [11:0]     pk_mag;
  logic [CntW-1:0] pk_pos, f_pos, l_pos;
  logic [15:0]     pk_lin, f_lin, l_lin;
  logic            seen;
  logic [CntW:0]   f1, l1;
  logic [2:0]      verdict;
  logic            take;

  assign q_ready = !out_valid || out_ready;
  assign take = q_valid && q_ready;

  always_comb begin
    pk_mag = peak_magnitude; pk_pos = peak_position; pk_lin = peak_linear;
    f_pos = first_position; f_lin = first_linear;
    l_pos = last_position; l_lin = last_linear; seen = echo_seen;
    if (q_data.mag > peak_magnitude) begin
      pk_mag = q_data.mag; pk_pos = sample_counter; pk_lin = q_data.lin;
    end
    if (q_data.mag > echo_threshold) begin
      if (!echo_seen) begin
        f_pos = sample_counter; f_lin = q_data.lin;
      end
      l_pos = sample_counter; l_lin = q_data.lin; seen = 1'b1;
    end
    f1 = {1'b0, f_pos} + 1'b1;
    l1 = {1'b0, l_pos} + 1'b1;
    if (pk_mag == 12'd0) verdict = VerdictSilent;
    else if (!seen) verdict = after_canceller ? VerdictRemoved : VerdictNoEcho;
    else if ({16'd0, canceller_taps} < 32'(f1)) verdict = VerdictBeyond;
    else if ({16'd0, canceller_taps} > 32'(f1) && {16'd0, canceller_taps} < 32'(l1))
      verdict = VerdictEndsOut;
    else verdict = VerdictWithin;
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) begin
      out_data.verdict <= verdict;
      out_data.peak_index <= IdxW'(pk_pos);
      out_data.peak_value <= pk_lin;
      out_data.first_index <= IdxW'(f_pos);
      out_data.first_value <= f_lin;
      out_data.last_index <= IdxW'(l_pos);
      out_data.last_value <= l_lin;
    end
    if (rst) begin
      out_valid <= 1'b0;
      sample_counter <= '0;
      peak_magnitude <= '0;
      echo_seen <= 1'b0;
      peak_position <= '0; peak_linear <= '0;
      first_position <= '0; first_linear <= '0;
      last_position <= '0; last_linear <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        if (q_data.last) begin
          out_valid <= 1'b1;
          sample_counter <= '0;
          peak_magnitude <= '0;
          echo_seen <= 1'b0;
          peak_position <= '0; peak_linear <= '0;
          first_position <= '0; first_linear <= '0;
          last_position <= '0; last_linear <= '0;
        end else begin
          peak_magnitude <= pk_mag;
          echo_seen <= seen;
          peak_position <= pk_pos; peak_linear <= pk_lin;
          first_position <= f_pos; first_linear <= f_lin;
          last_position <= l_pos; last_linear <= l_lin;
          if (sample_counter != CntW'(MAX_SAMPLES - 1))
            sample_counter <= sample_counter + 1'b1;
        end
      end
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_first_le_last: assert property (@(posedge clk) disable iff (rst)
    echo_seen |-> first_position <= last_position) else $error("echo span order");
  a_seen_thr: assert property (@(posedge clk) disable iff (rst)
    !echo_seen |-> first_position == '0 && last_position == '0)
    else $error("echo position without echo");
endmodule

@@ hw/rtl/echo_spike_profiler.sv @@
// top level of the echo spike profiler
`timescale 1ns / 1ps
// echo spike profiler: takes one g.711 code byte per cycle while in_ready is high,
// decodes it with the mu-law or a-law expander (mu_law register), and tracks the
// first strict peak and the first and last samples whose 12-bit magnitude exceeds
// echo_threshold. the request marked last_sample yields one result with indices,
// values and a verdict against canceller_taps, then tracking restarts. throughput
// is one request per cycle unless out_ready stalls the result; a request passes the
// decode register queue, then the result register. the user writes configuration
// while idle (not enforced by the block) via the cfg channel, which is always ready.
module echo_spike_profiler import esp_pkg::*; #(
  parameter int MAX_SAMPLES = MaxSamplesDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_req_t  cfg_data
);
  logic        mu_law, after_canceller;
  logic [15:0] canceller_taps;
  logic [11:0] echo_threshold;
  logic        q_valid, q_ready;
  dec_item_t   q_data;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      mu_law <= 1'b1;
      after_canceller <= 1'b0;
      canceller_taps <= 16'd128;
      echo_threshold <= 12'd11;
    end else if (cfg_valid) begin
      unique case (cfg_data.index)
        RegMuLaw:     mu_law <= cfg_data.data[0];
        RegAfterCanc: after_canceller <= cfg_data.data[0];
        RegTaps:      canceller_taps <= cfg_data.data[15:0];
        RegThreshold: echo_threshold <= cfg_data.data[11:0];
        default: ;
      endcase
    end
  end

  // decode side
  esp_front u_front (
    .clk, .rst, .mu_law,
    .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  // tracking side
  esp_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk, .rst, .after_canceller, .canceller_taps, .echo_threshold,
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
